// ===== rtl/ufbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ufbd_pkg: shared types and constants
// Field types, limits and register indexes of the fractional baud divider
// search core.
// ----------------------------------------------------------------------------
package ufbd_pkg;

  // Field widths
  localparam int PCLK_W   = 28;
  localparam int PCT_W    = 7;
  localparam int BAUD_W   = 22;
  localparam int DIV_W    = 16;
  localparam int FRAC_W   = 4;
  localparam int ERR_W    = 17;
  localparam int CFG_IDX_W = 1;

  // Divider unit widths: dividend holds mul * (pclk / 16), divisor holds a baud rate
  localparam int UCLK_W   = PCLK_W - 4;
  localparam int DVD_W    = FRAC_W + UCLK_W;
  localparam int DVS_W    = BAUD_W;
  localparam int CAND_W   = UCLK_W + 1;
  localparam int ACC_W    = BAUD_W + PCT_W;

  typedef logic [PCLK_W-1:0]    pclk_t;
  typedef logic [PCT_W-1:0]     pct_t;
  typedef logic [BAUD_W-1:0]    baud_t;
  typedef logic [DIV_W-1:0]     div_t;
  typedef logic [FRAC_W-1:0]    frac_t;
  typedef logic [ERR_W-1:0]     err_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DVD_W-1:0]     dvd_t;
  typedef logic [DVS_W-1:0]     dvs_t;

  // Search limits
  localparam err_t  NO_PAIR_ERROR = 17'd100000;
  localparam int    DIV_LIMIT     = 65536;
  localparam int    DIV_MIN       = 3;
  localparam frac_t FRAC_MAX      = 4'd15;
  localparam int    PERCENT_SCALE = 100;

  // Register indexes and reset values
  localparam cfg_idx_t CFG_PCLK_HZ = 1'b0;
  localparam cfg_idx_t CFG_ACC_PCT = 1'b1;
  localparam pclk_t    PCLK_RESET  = 28'd25000000;
  localparam pct_t     PCT_RESET   = 7'd3;

endpackage

// ===== rtl/ufbd_in_if.sv =====
// ----------------------------------------------------------------------------
// ufbd_in_if: request channel
// Carries the target baud rate with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufbd_in_if import ufbd_pkg::*; ();
  logic  valid;
  logic  ready;
  baud_t target_baud;

  modport source (output valid, output target_baud, input ready);
  modport sink   (input valid, input target_baud, output ready);
endinterface

// ===== rtl/ufbd_out_if.sv =====
// ----------------------------------------------------------------------------
// ufbd_out_if: result channel
// Carries the chosen divider settings with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufbd_out_if import ufbd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  accepted;
  div_t  divisor;
  frac_t mul_val;
  frac_t div_add_val;
  err_t  best_error;

  modport source (output valid, output accepted, output divisor, output mul_val,
                  output div_add_val, output best_error, input ready);
  modport sink   (input valid, input accepted, input divisor, input mul_val,
                  input div_add_val, input best_error, output ready);
endinterface

// ===== rtl/ufbd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ufbd_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufbd_cfg_if import ufbd_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t addr;
  pclk_t    wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== rtl/ufbd_div.sv =====
// ----------------------------------------------------------------------------
// ufbd_div: serial restoring divider
// Unsigned divide, one quotient bit per cycle; done pulses with the results.
// ----------------------------------------------------------------------------
module ufbd_div import ufbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  dvd_t dividend,
  input  dvs_t divisor,
  output logic done,
  output dvd_t quotient,
  output dvs_t remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dvd_t             quo_r, quo_nxt;
  dvs_t             rem_r, rem_nxt;
  dvs_t             dvs_r, dvs_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/uart_fractional_baud_divider_search_core.sv =====
// ----------------------------------------------------------------------------
// uart_fractional_baud_divider_search_core: fractional baud divider search
// Finds divisor, multiplier and add value of a 16x-oversampling UART for a
// requested baud rate, using one shared serial divider.
// ----------------------------------------------------------------------------
// One request takes one target baud rate and returns one result. The search
// walks multiplier 1..15 (outer) and add value 0..15 (inner); each pair runs
// up to three divisions through a single restoring divider that resolves one
// quotient bit per cycle: the scaled clock, the rounded divisor and the
// achieved baud rate. A pair whose divisor falls outside 3..65535 skips the
// third division. The search ends early at the first pair with zero error,
// and a zero target goes to the output register without a search. The
// request channel is ready only while no search runs; a finished result
// waits in the output register, so the next request is taken while it is
// pending. Write pclk_hz and accept_error_percent only while no request is
// in flight.
module uart_fractional_baud_divider_search_core import ufbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ufbd_in_if.sink    in_ch,
  ufbd_out_if.source out_ch,
  ufbd_cfg_if.sink   cfg_ch
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;  // start scaled clock division
  localparam logic [3:0] S_WAIT1 = 4'd2;  // scaled clock ready, start divisor division
  localparam logic [3:0] S_WAIT2 = 4'd3;  // round divisor, start rate division
  localparam logic [3:0] S_WAIT3 = 4'd4;  // compare error, keep the best pair
  localparam logic [3:0] S_NEXT  = 4'd5;  // advance to the next pair
  localparam logic [3:0] S_OUT   = 4'd6;  // hand result to the output register

  logic [3:0]        state_r, state_nxt;

  // Configuration
  pclk_t             pclk_r, pclk_nxt;
  pct_t              pct_r, pct_nxt;

  // Search working registers
  baud_t             baud_r, baud_nxt;
  frac_t             mul_r, mul_nxt;
  frac_t             add_r, add_nxt;
  logic [UCLK_W-1:0] scaled_r, scaled_nxt;
  frac_t             best_mul_r, best_mul_nxt;
  frac_t             best_add_r, best_add_nxt;
  div_t              best_div_r, best_div_nxt;
  err_t              best_err_r, best_err_nxt;
  div_t              cand_div_r, cand_div_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  div_t              out_div_r, out_div_nxt;
  frac_t             out_mul_r, out_mul_nxt;
  frac_t             out_add_r, out_add_nxt;
  err_t              out_err_r, out_err_nxt;

  // Shared divider
  logic              div_start;
  dvd_t              div_dvd;
  dvs_t              div_dvs;
  logic              div_done;
  dvd_t              div_quo;
  dvs_t              div_rem;

  logic              in_fire;
  logic              out_load;
  logic [UCLK_W-1:0] uclk;
  dvd_t              scale_prod;
  logic              round_up;
  logic [CAND_W-1:0] cand;
  logic              cand_ok;
  logic [UCLK_W-1:0] got;
  logic [UCLK_W-1:0] baud_ext;
  logic [UCLK_W-1:0] err;
  logic              better;
  logic              last_pair;
  logic [ACC_W-1:0]  err_budget;
  logic [ACC_W-1:0]  err_floor;
  logic              accept_now;

  ufbd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_fire = in_ch.valid && (state_r == S_IDLE);

  // UART clock is pclk / 16; scaled clock numerator is mul * uclk
  assign uclk       = pclk_r[PCLK_W-1:4];
  assign scale_prod = DVD_W'(mul_r) * DVD_W'(uclk);

  // Round to nearest with ties down: bump when remainder exceeds half the target
  assign round_up = div_rem > DVS_W'(baud_r >> 1);
  assign cand     = CAND_W'(div_quo[UCLK_W-1:0]) + CAND_W'(round_up);
  assign cand_ok  = (cand >= CAND_W'(DIV_MIN)) && (cand < CAND_W'(DIV_LIMIT));

  // Achieved rate and its absolute error
  assign got      = div_quo[UCLK_W-1:0];
  assign baud_ext = UCLK_W'(baud_r);
  assign err      = (got <= baud_ext) ? (baud_ext - got) : (got - baud_ext);
  assign better   = err < UCLK_W'(best_err_r);

  assign last_pair = (mul_r == FRAC_MAX) && (add_r == FRAC_MAX);

  // err < floor(baud * pct / 100)  <=>  baud * pct >= 100 * (err + 1)
  assign err_budget = ACC_W'(baud_r) * ACC_W'(pct_r);
  assign err_floor  = (ACC_W'(best_err_r) + ACC_W'(1)) * ACC_W'(PERCENT_SCALE);
  assign accept_now = err_budget >= err_floor;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    baud_nxt     = baud_r;
    mul_nxt      = mul_r;
    add_nxt      = add_r;
    scaled_nxt   = scaled_r;
    best_mul_nxt = best_mul_r;
    best_add_nxt = best_add_r;
    best_div_nxt = best_div_r;
    best_err_nxt = best_err_r;
    cand_div_nxt = cand_div_r;
    div_start    = 1'b0;
    div_dvd      = scale_prod;
    div_dvs      = DVS_W'(mul_r) + DVS_W'(add_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          baud_nxt     = in_ch.target_baud;
          mul_nxt      = frac_t'(1);
          add_nxt      = '0;
          best_mul_nxt = frac_t'(1);
          best_add_nxt = '0;
          best_div_nxt = '0;
          best_err_nxt = NO_PAIR_ERROR;
          // no pair can work for a zero target
          state_nxt    = (in_ch.target_baud == '0) ? S_OUT : S_SCALE;
        end
      end
      S_SCALE: begin
        div_start = 1'b1;
        state_nxt = S_WAIT1;
      end
      S_WAIT1: begin
        if (div_done) begin
          scaled_nxt = div_quo[UCLK_W-1:0];
          div_start  = 1'b1;
          div_dvd    = div_quo;
          div_dvs    = baud_r;
          state_nxt  = S_WAIT2;
        end
      end
      S_WAIT2: begin
        if (div_done) begin
          if (cand_ok) begin
            cand_div_nxt = cand[DIV_W-1:0];
            div_start    = 1'b1;
            div_dvd      = DVD_W'(scaled_r);
            div_dvs      = DVS_W'(cand[DIV_W-1:0]);
            state_nxt    = S_WAIT3;
          end else begin
            // divisor out of range: drop the pair
            state_nxt = S_NEXT;
          end
        end
      end
      S_WAIT3: begin
        if (div_done) begin
          state_nxt = S_NEXT;
          if (better) begin
            best_mul_nxt = mul_r;
            best_add_nxt = add_r;
            best_div_nxt = cand_div_r;
            best_err_nxt = err[ERR_W-1:0];
            // exact hit ends the search
            if (err == '0) begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_NEXT: begin
        if (last_pair) begin
          state_nxt = S_OUT;
        end else begin
          if (add_r == FRAC_MAX) begin
            add_nxt = '0;
            mul_nxt = mul_r + 1'b1;
          end else begin
            add_nxt = add_r + 1'b1;
          end
          state_nxt = S_SCALE;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: hold until taken, load the finished search when free
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_div_nxt   = out_div_r;
    out_mul_nxt   = out_mul_r;
    out_add_nxt   = out_add_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = accept_now;
      out_div_nxt   = best_div_r;
      out_mul_nxt   = best_mul_r;
      out_add_nxt   = best_add_r;
      out_err_nxt   = best_err_r;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration writes; unknown indexes are ignored
  always_comb begin
    pclk_nxt = pclk_r;
    pct_nxt  = pct_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_PCLK_HZ: pclk_nxt = cfg_ch.wdata;
        CFG_ACC_PCT: pct_nxt  = cfg_ch.wdata[PCT_W-1:0];
        default:     pclk_nxt = pclk_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pclk_r      <= PCLK_RESET;
      pct_r       <= PCT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pclk_r      <= pclk_nxt;
      pct_r       <= pct_nxt;
    end
    baud_r     <= baud_nxt;
    mul_r      <= mul_nxt;
    add_r      <= add_nxt;
    scaled_r   <= scaled_nxt;
    best_mul_r <= best_mul_nxt;
    best_add_r <= best_add_nxt;
    best_div_r <= best_div_nxt;
    best_err_r <= best_err_nxt;
    cand_div_r <= cand_div_nxt;
    out_acc_r  <= out_acc_nxt;
    out_div_r  <= out_div_nxt;
    out_mul_r  <= out_mul_nxt;
    out_add_r  <= out_add_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.divisor     = out_div_r;
  assign out_ch.mul_val     = out_mul_r;
  assign out_ch.div_add_val = out_add_r;
  assign out_ch.best_error  = out_err_r;

endmodule

// ===== rtl/ufbd_chk.sv =====
// ----------------------------------------------------------------------------
// ufbd_chk: port checker for the baud divider search core
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module ufbd_chk import ufbd_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input logic  out_accepted,
  input div_t  out_divisor,
  input frac_t out_mul_val,
  input frac_t out_div_add_val,
  input err_t  out_best_error
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divisor) &&
    $stable(out_mul_val) && $stable(out_div_add_val) &&
    $stable(out_best_error) && $stable(out_accepted))
    else $error("result changed while stalled");

  // A search occupies the core: no back-to-back request transactions
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a search runs");

  // No usable pair gives the fixed fallback result
  a_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor == '0) |->
    (out_mul_val == frac_t'(1)) && (out_div_add_val == '0) &&
    (out_best_error == NO_PAIR_ERROR))
    else $error("fallback result fields inconsistent");

  // A chosen pair has an in-range divisor, a real multiplier and a smaller error
  a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor != '0) |->
    (out_divisor >= div_t'(DIV_MIN)) && (out_mul_val != '0) &&
    (out_best_error < NO_PAIR_ERROR))
    else $error("chosen pair out of range");

endmodule

bind uart_fractional_baud_divider_search_core ufbd_chk u_ufbd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_accepted    (out_ch.accepted),
  .out_divisor     (out_ch.divisor),
  .out_mul_val     (out_ch.mul_val),
  .out_div_add_val (out_ch.div_add_val),
  .out_best_error  (out_ch.best_error)
);

// ===== tb/uart_fractional_baud_divider_search_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_fractional_baud_divider_search_core_tb: self-checking divider search bench
// Sends target baud rates through the request channel under several clock and
// tolerance settings. A scoreboard predicts each divider choice on acceptance
// and compares every returned result, field by field, in order.
// ----------------------------------------------------------------------------
module uart_fractional_baud_divider_search_core_tb import ufbd_pkg::*; ();

  // Receiver hold-off that lets the core fill up and back-pressure requests
  localparam int RX_HOLD_CYCLES = 600;
  // Cycles to let pass after the last result before reconfiguring or ending
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 200;
  // Watchdog limit; allow several times the slowest run
  localparam longint TIMEOUT_NS = 150_000_000;

  localparam int unsigned STD_RATES [12] = '{300, 1200, 2400, 4800, 9600, 19200,
                                             38400, 57600, 115200, 230400,
                                             460800, 921600};

  typedef struct packed {
    logic  accepted;
    div_t  divisor;
    frac_t mul_val;
    frac_t div_add_val;
    err_t  best_error;
  } divider_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the registers and the expected results
  // --------------------------------------------------------------------------
  class divider_scoreboard;
    pclk_t           pclk_hz;
    pct_t            accept_pct;
    divider_result_t expected_q[$];
    int unsigned     errors;

    function new();
      pclk_hz    = PCLK_RESET;
      accept_pct = PCT_RESET;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, pclk_t value);
      if (idx == CFG_PCLK_HZ) begin
        pclk_hz = value;
      end else begin
        accept_pct = value[PCT_W-1:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Walk multiplier 1..15 and add value 0..15, keep the first strictly best pair
    function divider_result_t search(baud_t baud);
      int unsigned     uclk, b, m, a, scaled, quo, achieved, err, best_err;
      longint unsigned thresh;
      bit              exact;
      divider_result_t r;
      uclk     = pclk_hz >> 4;
      b        = baud;
      exact    = 1'b0;
      best_err = NO_PAIR_ERROR;
      r        = '{accepted: 1'b0, divisor: '0, mul_val: 4'd1, div_add_val: '0,
                   best_error: NO_PAIR_ERROR};
      if (b != 0) begin
        for (m = 1; m <= FRAC_MAX && !exact; m++) begin
          for (a = 0; a <= FRAC_MAX && !exact; a++) begin
            scaled = (m * uclk) / (m + a);
            quo    = scaled / b;
            // round to nearest, ties down
            if (scaled % b > b / 2) quo++;
            if (quo < DIV_MIN || quo >= DIV_LIMIT) continue;
            achieved = scaled / quo;
            err      = (achieved <= b) ? b - achieved : achieved - b;
            if (err < best_err) begin
              best_err      = err;
              r.mul_val     = frac_t'(m);
              r.div_add_val = frac_t'(a);
              r.divisor     = div_t'(quo);
              exact         = (err == 0);
            end
          end
        end
      end
      thresh       = (longint'(b) * accept_pct) / PERCENT_SCALE;
      r.best_error = err_t'(best_err);
      r.accepted   = (best_err < thresh);
      return r;
    endfunction

    function void note_request(baud_t baud);
      expected_q.push_back(search(baud));
    endfunction

    function void check_result(divider_result_t got);
      divider_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with no request pending: divisor %0d", got.divisor);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.divisor !== want.divisor) begin
        $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
        errors++;
      end
      if (got.mul_val !== want.mul_val) begin
        $error("mul_val: expected %0d, got %0d", want.mul_val, got.mul_val);
        errors++;
      end
      if (got.div_add_val !== want.div_add_val) begin
        $error("div_add_val: expected %0d, got %0d", want.div_add_val, got.div_add_val);
        errors++;
      end
      if (got.best_error !== want.best_error) begin
        $error("best_error: expected %0d, got %0d", want.best_error, got.best_error);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the core
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ufbd_in_if  in_bus ();
  ufbd_out_if out_bus ();
  ufbd_cfg_if cfg_bus ();

  uart_fractional_baud_divider_search_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  divider_scoreboard sb = new();

  // Percent of cycles in which each side idles; changed between phases
  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 51;
  // Raised by the stimulus to make the receiver hold off for a long stretch
  bit          rx_hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge, before the core's
  // registers update, and hand the transaction to the scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.addr, cfg_bus.wdata);
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(in_bus.target_baud);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result('{accepted:    out_bus.accepted,
                          divisor:     out_bus.divisor,
                          mul_val:     out_bus.mul_val,
                          div_add_val: out_bus.div_add_val,
                          best_error:  out_bus.best_error});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: toggle ready at the falling edge; on request, drop ready
  // for a fixed count of cycles so results back up into the core
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req   = 1'b0;
        out_bus.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All of them return at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one request; leave valid high after acceptance so a following
  // request can keep it high without a gap
  task automatic send_request(baud_t baud);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.target_baud = baud;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Drop the request, wait for every expected result, then let the core rest
  task automatic settle();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, pclk_t value);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = idx;
    cfg_bus.wdata = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Reconfigure while idle; fill the unused upper bits of the percent write
  // with noise, since only the low bits belong to the register
  task automatic apply_config(pclk_t hz, pct_t pct);
    pclk_t pct_word;
    settle();
    pct_word            = pclk_t'($urandom());
    pct_word[PCT_W-1:0] = pct;
    write_reg(CFG_PCLK_HZ, hz);
    write_reg(CFG_ACC_PCT, pct_word);
  endtask

  // One random configuration followed by a batch of random targets: mostly
  // standard rates and exact fractions of the UART clock, some anything goes
  task automatic random_phase(int n);
    pclk_t       hz;
    int unsigned uclk;
    baud_t       baud;
    hz   = pclk_t'($urandom_range(1_000_000, 268_435_455));
    uclk = hz >> 4;
    apply_config(hz, pct_t'($urandom_range(0, 127)));
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: baud = baud_t'(STD_RATES[$urandom_range(11)]);
        4, 5:       baud = baud_t'($urandom_range(300, 4_000_000));
        6, 7:       baud = baud_t'(uclk / $urandom_range(3, 4096));
        8:          baud = baud_t'($urandom_range(1, 299));
        default:    baud = baud_t'($urandom());
      endcase
      send_request(baud);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.target_baud = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.addr       = CFG_PCLK_HZ;
    cfg_bus.wdata      = '0;

    // Hold reset low, then release it at a falling edge
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: zero target, smallest and largest field values, common
    // rates, a rate hit exactly on the first pair, and one too fast for any
    // usable divisor
    send_request(baud_t'(0));
    send_request(baud_t'(1));
    send_request(baud_t'(22'h3FFFFF));
    send_request(baud_t'(300));
    send_request(baud_t'(9600));
    send_request(baud_t'(115200));
    send_request(baud_t'(520833));
    send_request(baud_t'(1562500));
    send_request(baud_t'(15625));
    send_request(baud_t'(4000000));

    // Back-pressure: once the long searches have drained, hold the receiver
    // off while short requests keep coming, so one result waits in the output
    // register, the next search parks behind it and the input stalls
    settle();
    rx_hold_req = 1'b1;
    send_request(baud_t'(0));
    send_request(baud_t'(15625));
    send_request(baud_t'(0));
    send_request(baud_t'(15625));
    send_request(baud_t'(0));

    // Clock below 16 Hz: nothing usable; percent at its top value
    apply_config(pclk_t'(10), pct_t'(127));
    send_request(baud_t'(9600));
    send_request(baud_t'(1));

    // Fastest clock the register holds, zero tolerance: never accepted
    apply_config(pclk_t'(28'hFFFFFFF), pct_t'(0));
    send_request(baud_t'(115200));
    send_request(baud_t'(22'h3FFFFF));
    send_request(baud_t'(1));

    // Slowest clock that still yields a UART clock
    apply_config(pclk_t'(16), pct_t'(100));
    send_request(baud_t'(1));

    // Crystal clock with standard rates: 9600 divides exactly, 921600 is too fast for any usable divisor
    apply_config(pclk_t'(14_745_600), pct_t'(100));
    send_request(baud_t'(921600));
    send_request(baud_t'(9600));

    // Random part: idle mostly on the receiver, then mostly on the sender,
    // then neither side idles
    tx_idle_pct = 36;
    rx_idle_pct = 51;
    random_phase(26);
    tx_idle_pct = 51;
    rx_idle_pct = 36;
    random_phase(26);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(26);

    // Drain, then give late or spurious results a chance to show up
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: end a hung run as a failure
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
